@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define PSM_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psm assertion failed");

// clocked check, also live during reset
`define PSM_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("psm assertion failed");

`endif

@@ sv/psm_pkg.sv @@
// Types, constants and helpers of the partitioned spectral MAC
`default_nettype none
package psm_pkg;

  localparam int CHANNELS = 2;
  localparam int SEGMENTS = 16;
  localparam int BINS     = 257;

  localparam int VAL_W   = 24;
  localparam int FRAC    = 23;
  localparam int BIN_W   = 9;
  localparam int SEGF_W  = 4;
  localparam int SHIFT_W = 4;
  localparam int ASEG_W  = 5;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_W   = 32;

  localparam int DEPTH  = CHANNELS * SEGMENTS * BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(SEGMENTS + 1);
  localparam int PROD_W = 2 * VAL_W;
  localparam int CMB_W  = PROD_W + 1;
  localparam int TERM_W = CMB_W - FRAC;
  localparam int ACC_W  = TERM_W + CNT_W;
  localparam int ENTRY_W = 2 * VAL_W;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_SHIFT = 1'd0,
    CFG_ACTIVE_SEGS = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } psm_state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic                    channel;
    logic [SEGF_W-1:0]       segment;
    logic [BIN_W-1:0]        bin;
    logic signed [VAL_W-1:0] value_re;
    logic signed [VAL_W-1:0] value_im;
    logic                    end_of_block;
  } in_item_t;

  typedef struct packed {
    logic                    out_channel;
    logic [BIN_W-1:0]        out_bin;
    logic signed [OUT_W-1:0] acc_re;
    logic signed [OUT_W-1:0] acc_im;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic clr_acc;
    logic valid;
  } mac_ctrl_t;

  typedef struct packed {
    logic                    busy;
    logic signed [OUT_W-1:0] acc_re;
    logic signed [OUT_W-1:0] acc_im;
  } mac_stat_t;

  function automatic logic [ADDR_W-1:0] store_idx(logic ch, logic [SLOT_W-1:0] seg,
                                                   logic [BIN_W-1:0] bin);
    return ADDR_W'((32'(ch) * SEGMENTS + 32'(seg)) * BINS + 32'(bin));
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [ACC_W-1:0] a);
    logic signed [63:0] w;
    w = 64'(a);
    if (w > SAT_MAX) w = SAT_MAX;
    if (w < SAT_MIN) w = SAT_MIN;
    return OUT_W'(w);
  endfunction

endpackage
`default_nettype wire

@@ sv/psm_if.sv @@
// Input and result channel interfaces
`default_nettype none
interface psm_in_if import psm_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface psm_out_if import psm_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/psm_cmac.sv @@
// Shared complex multiply-accumulate pipeline
`default_nettype none
module psm_cmac import psm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctrl_t               ctrl,
  input  logic signed [VAL_W-1:0] dr,
  input  logic signed [VAL_W-1:0] di,
  input  logic signed [VAL_W-1:0] fr,
  input  logic signed [VAL_W-1:0] fi,
  output mac_stat_t               stat
);

  logic                     v1_r, v2_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [CMB_W-1:0]  c_re_r, c_im_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [TERM_W-1:0] term_re, term_im;

  // arithmetic shift by FRAC, then keep the significant bits
  assign term_re = $signed(c_re_r[CMB_W-1:FRAC]);
  assign term_im = $signed(c_im_r[CMB_W-1:FRAC]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p_rr_r <= dr * fr;
    p_ii_r <= di * fi;
    p_ri_r <= dr * fi;
    p_ir_r <= di * fr;
    c_re_r <= CMB_W'(p_rr_r) - CMB_W'(p_ii_r);
    c_im_r <= CMB_W'(p_ri_r) + CMB_W'(p_ir_r);
    if (ctrl.clr_acc) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v2_r) begin
      acc_re_r <= acc_re_r + ACC_W'(term_re);
      acc_im_r <= acc_im_r + ACC_W'(term_im);
    end
  end

  assign stat.busy   = ctrl.valid | v1_r | v2_r;
  assign stat.acc_re = sat_out(acc_re_r);
  assign stat.acc_im = sat_out(acc_im_r);

endmodule
`default_nettype wire

@@ sv/partitioned_spectral_mac_unit.sv @@
// Top level: delay line and filter stores, sequencer, output register
// Push: PUSH writes the delay line, ISSUE reads S = active_segments clamped to
//   1..16 segments, DRAIN empties the MAC, DONE waits for the output register.
// Load: written in the accepting cycle, next item taken the cycle after.
// Reset and clear: a zeroing pass over all 8224 delay-line entries, one entry
//   per cycle, with no item taken meanwhile; config writes still land.
`default_nettype none
module partitioned_spectral_mac_unit import psm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  psm_in_if.sink               in_ch,
  psm_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  psm_state_t state_r, state_nxt;

  logic [SHIFT_W-1:0] scale_shift_r;
  logic [ASEG_W-1:0]  active_segs_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic [SLOT_W-1:0]  fseg_r;
  in_item_t           item_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic               iss_v_r;
  logic [ENTRY_W-1:0] dl_rd_r, fs_rd_r;

  logic [ENTRY_W-1:0] dl_mem [DEPTH];
  logic [ENTRY_W-1:0] fs_mem [DEPTH];

  logic               in_acc, item_ok, load_go, push_go, clear_go;
  logic [CNT_W-1:0]   segs_eff, slot_inc;
  logic [SLOT_W-1:0]  slot_use;
  logic               in_ready, dl_we, rd_issue, out_load;
  logic [ADDR_W-1:0]  dl_waddr, dl_raddr, fs_raddr;
  logic [ENTRY_W-1:0] dl_wdata;
  logic signed [VAL_W-1:0] sh_re, sh_im;
  mac_ctrl_t          mac_ctrl;
  mac_stat_t          mac_st;

  assign in_acc   = in_ch.valid && in_ready;
  assign item_ok  = (32'(in_ch.data.channel) < CHANNELS) && (32'(in_ch.data.bin) < BINS);
  assign load_go  = in_acc && (in_ch.data.opcode == OP_LOAD) && item_ok
                    && (32'(in_ch.data.segment) < SEGMENTS);
  assign push_go  = in_acc && (in_ch.data.opcode == OP_PUSH) && item_ok;
  assign clear_go = in_acc && (in_ch.data.opcode == OP_CLEAR);

  always_comb begin
    if (active_segs_r == '0) begin
      segs_eff = CNT_W'(1);
    end else if (32'(active_segs_r) > SEGMENTS) begin
      segs_eff = CNT_W'(SEGMENTS);
    end else begin
      segs_eff = CNT_W'(active_segs_r);
    end
  end

  assign slot_use = (CNT_W'(slot_r) >= segs_eff) ? '0 : slot_r;
  assign slot_inc = CNT_W'(slot_r) + CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (clear_go) state_nxt = ST_CLEAR;
        else if (push_go) state_nxt = ST_PUSH;
      end
      ST_PUSH: state_nxt = ST_ISSUE;
      ST_ISSUE: begin
        if (rd_cnt_r == segs_eff - CNT_W'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mac_st.busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    dl_we    = 1'b0;
    rd_issue = 1'b0;
    out_load = 1'b0;
    mac_ctrl = '0;
    unique case (state_r)
      ST_CLEAR: dl_we = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_PUSH: begin
        dl_we = 1'b1;
        mac_ctrl.clr_acc = 1'b1;
      end
      ST_ISSUE: rd_issue = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
    mac_ctrl.valid = iss_v_r;
  end

  assign in_ch.ready = in_ready;

  assign sh_re    = item_r.value_re >>> scale_shift_r;
  assign sh_im    = item_r.value_im >>> scale_shift_r;
  assign dl_waddr = (state_r == ST_CLEAR) ? clr_addr_r
                  : store_idx(item_r.channel, slot_r, item_r.bin);
  assign dl_wdata = (state_r == ST_CLEAR) ? '0 : {sh_re, sh_im};
  assign dl_raddr = store_idx(item_r.channel, rd_cnt_r[SLOT_W-1:0], item_r.bin);
  assign fs_raddr = store_idx(item_r.channel, fseg_r, item_r.bin);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      scale_shift_r <= SHIFT_W'(9);
      active_segs_r <= ASEG_W'(16);
      slot_r        <= '0;
      clr_addr_r    <= '0;
      rd_cnt_r      <= '0;
      fseg_r        <= '0;
      iss_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_v_r <= rd_issue;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCALE_SHIFT: scale_shift_r <= cfg_wdata[SHIFT_W-1:0];
          CFG_ACTIVE_SEGS: active_segs_r <= cfg_wdata[ASEG_W-1:0];
          default: ;
        endcase
      end
      if (clear_go) begin
        clr_addr_r <= '0;
        slot_r     <= '0;
      end else if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (push_go) slot_r <= slot_use;
      if (out_load && item_r.end_of_block) begin
        slot_r <= (slot_inc >= segs_eff) ? '0 : SLOT_W'(slot_inc);
      end
      if (state_r == ST_PUSH) begin
        rd_cnt_r <= '0;
        fseg_r   <= slot_r;
      end else if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        fseg_r   <= (fseg_r == '0) ? SLOT_W'(segs_eff - CNT_W'(1)) : fseg_r - SLOT_W'(1);
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push_go) item_r <= in_ch.data;
    if (out_load) begin
      out_data_r.out_channel <= item_r.channel;
      out_data_r.out_bin     <= item_r.bin;
      out_data_r.acc_re      <= mac_st.acc_re;
      out_data_r.acc_im      <= mac_st.acc_im;
      out_data_r.last        <= item_r.end_of_block;
    end
  end

  // delay line store
  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_waddr] <= dl_wdata;
    dl_rd_r <= dl_mem[dl_raddr];
  end

  // filter spectra store
  always_ff @(posedge clk) begin
    if (load_go) begin
      fs_mem[store_idx(in_ch.data.channel, in_ch.data.segment, in_ch.data.bin)] <=
        {in_ch.data.value_re, in_ch.data.value_im};
    end
    fs_rd_r <= fs_mem[fs_raddr];
  end

  psm_cmac u_cmac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .dr    ($signed(dl_rd_r[ENTRY_W-1:VAL_W])),
    .di    ($signed(dl_rd_r[VAL_W-1:0])),
    .fr    ($signed(fs_rd_r[ENTRY_W-1:VAL_W])),
    .fi    ($signed(fs_rd_r[VAL_W-1:0])),
    .stat  (mac_st)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule
`default_nettype wire

@@ sv/psm_checker.sv @@
// Port-level checker for the partitioned spectral MAC, with its bind
`default_nettype none
`include "assert_macros.svh"
module psm_checker import psm_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic [1:0]       in_opcode,
  input wire logic             in_channel,
  input wire logic [BIN_W-1:0] in_bin,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire out_item_t        out_data
);

  logic in_push;

  assign in_push = in_valid && in_ready && in_opcode == OP_PUSH
                   && 32'(in_channel) < CHANNELS && 32'(in_bin) < BINS;

  `PSM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `PSM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data))
  `PSM_ASSERT(a_push_busy, in_push |=> !in_ready)
  `PSM_ASSERT(a_clear_busy, in_valid && in_ready && in_opcode == OP_CLEAR |=> !in_ready)
  `PSM_ASSERT_RST(a_reset_busy, !rst_n |=> !in_ready)

endmodule

bind partitioned_spectral_mac_unit psm_checker u_psm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_opcode  (in_ch.data.opcode),
  .in_channel (in_ch.data.channel),
  .in_bin     (in_ch.data.bin),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_data   (out_ch.data)
);
`default_nettype wire

@@ test/partitioned_spectral_mac_unit_tb.sv @@
// Testbench for partitioned_spectral_mac_unit: directed and random beats checked by a predictor
`timescale 1ns / 100ps
module partitioned_spectral_mac_unit_tb;
  import psm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam int KEYS = CHANNELS * BINS;

  class spectral_mac_predictor;
    logic signed [VAL_W-1:0] dl_re [CHANNELS][SEGMENTS][BINS];
    logic signed [VAL_W-1:0] dl_im [CHANNELS][SEGMENTS][BINS];
    logic signed [VAL_W-1:0] fs_re [CHANNELS][SEGMENTS][BINS];
    logic signed [VAL_W-1:0] fs_im [CHANNELS][SEGMENTS][BINS];
    int unsigned slot;
    int unsigned shift_amt;
    int unsigned seg_setting;
    out_item_t   expected_bins [$];
    int          errors;

    function new();
      clear_delay();
      foreach (fs_re[c, s, b]) begin
        fs_re[c][s][b] = '0;
        fs_im[c][s][b] = '0;
      end
      shift_amt   = 9;
      seg_setting = 16;
      errors      = 0;
    endfunction

    function void clear_delay();
      foreach (dl_re[c, s, b]) begin
        dl_re[c][s][b] = '0;
        dl_im[c][s][b] = '0;
      end
      slot = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, int unsigned val);
      if (idx == CFG_SCALE_SHIFT) shift_amt = val & 32'hF;
      else seg_setting = val & 32'h1F;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void accept_item(in_item_t it);
      int unsigned ch, bin, segs, fseg;
      longint      sum_re, sum_im, dr, di, fr, fi;
      out_item_t   res;
      ch  = it.channel;
      bin = it.bin;
      if (it.opcode == OP_CLEAR) begin
        clear_delay();
        return;
      end
      if (it.opcode != OP_LOAD && it.opcode != OP_PUSH) return;
      if (ch >= CHANNELS || bin >= BINS) return;
      if (it.opcode == OP_LOAD) begin
        if (it.segment >= SEGMENTS) return;
        fs_re[ch][it.segment][bin] = it.value_re;
        fs_im[ch][it.segment][bin] = it.value_im;
        return;
      end
      segs = seg_setting;
      if (segs < 1) segs = 1;
      if (segs > SEGMENTS) segs = SEGMENTS;
      if (slot >= segs) slot = 0;
      dl_re[ch][slot][bin] = $signed(it.value_re) >>> shift_amt;
      dl_im[ch][slot][bin] = $signed(it.value_im) >>> shift_amt;
      sum_re = 0;
      sum_im = 0;
      for (int unsigned r = 0; r < segs; r++) begin
        fseg = (slot + segs - r) % segs;
        dr = dl_re[ch][r][bin];
        di = dl_im[ch][r][bin];
        fr = fs_re[ch][fseg][bin];
        fi = fs_im[ch][fseg][bin];
        sum_re += (dr * fr - di * fi) >>> FRAC;
        sum_im += (dr * fi + di * fr) >>> FRAC;
      end
      res.out_channel = it.channel;
      res.out_bin     = it.bin;
      res.acc_re      = OUT_W'(sat32(sum_re));
      res.acc_im      = OUT_W'(sat32(sum_im));
      res.last        = it.end_of_block;
      expected_bins.push_back(res);
      if (it.end_of_block) begin
        slot++;
        if (slot >= segs) slot = 0;
      end
    endfunction

    function void compare_field(string fname, longint want_v, longint got_v);
      if (want_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
      end
    endfunction

    function void check_bin_result(out_item_t got);
      out_item_t want;
      if (expected_bins.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = expected_bins.pop_front();
      compare_field("out_channel", want.out_channel, got.out_channel);
      compare_field("out_bin", want.out_bin, got.out_bin);
      compare_field("acc_re", want.acc_re, got.acc_re);
      compare_field("acc_im", want.acc_im, got.acc_im);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  psm_in_if  in_ch();
  psm_out_if out_ch();

  spectral_mac_predictor pred;

  int                burst_left;
  int                clears_left;
  int                build_key;
  bit [SEGMENTS-1:0] filter_mask [KEYS];
  bit                key_ready [KEYS];
  int                ready_keys [$];

  partitioned_spectral_mac_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t make_item(logic [1:0] op, logic ch, logic [SEGF_W-1:0] seg,
                                         logic [BIN_W-1:0] bin, logic signed [VAL_W-1:0] re,
                                         logic signed [VAL_W-1:0] im, logic eob);
    in_item_t it;
    it.opcode       = op;
    it.channel      = ch;
    it.segment      = seg;
    it.bin          = bin;
    it.value_re     = re;
    it.value_im     = im;
    it.end_of_block = eob;
    return it;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return VAL_W'($urandom_range(0, 511)) - VAL_W'(256);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic void note_load(int key, int seg);
    filter_mask[key][seg] = 1'b1;
    if (&filter_mask[key] && !key_ready[key]) begin
      key_ready[key] = 1'b1;
      ready_keys.push_back(key);
    end
  endfunction

  // entered at a falling edge, returns at the falling edge after the beat
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pred.accept_item(it);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (pred.expected_bins.size() != 0) @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    pred.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic send_load(int key, int seg, logic signed [VAL_W-1:0] re,
                           logic signed [VAL_W-1:0] im);
    send_item(make_item(OP_LOAD, 1'(key / BINS), SEGF_W'(seg), BIN_W'(key % BINS), re, im,
                        1'($urandom)));
    note_load(key, seg);
  endtask

  task automatic send_push(int ch, int bin, logic signed [VAL_W-1:0] re,
                           logic signed [VAL_W-1:0] im, logic eob);
    send_item(make_item(OP_PUSH, 1'(ch), SEGF_W'($urandom), BIN_W'(bin), re, im, eob));
  endtask

  task automatic run_random_phase(int n);
    int counted;
    int sel;
    int key;
    int seg;
    counted = 0;
    while (counted < n) begin
      sel = $urandom_range(0, 99);
      if (clears_left > 0 && $urandom_range(0, 299) == 0) begin
        clears_left--;
        send_item(make_item(OP_CLEAR, 1'($urandom), SEGF_W'($urandom), BIN_W'($urandom),
                            pick_value(), pick_value(), 1'($urandom)));
        counted++;
      end else if (sel < 58) begin
        key = ready_keys[$urandom_range(0, ready_keys.size() - 1)];
        send_push(key / BINS, key % BINS, pick_value(), pick_value(),
                  $urandom_range(0, 5) == 0);
        counted++;
      end else if (sel < 76) begin
        if (build_key < 0) begin
          do build_key = $urandom_range(0, KEYS - 1); while (key_ready[build_key]);
        end
        seg = 0;
        for (int s = 0; s < SEGMENTS; s++) begin
          if (!filter_mask[build_key][s]) begin
            seg = s;
            break;
          end
        end
        key = build_key;
        send_load(key, seg, pick_value(), pick_value());
        if (key_ready[key]) build_key = -1;
        counted++;
      end else if (sel < 86) begin
        key = ready_keys[$urandom_range(0, ready_keys.size() - 1)];
        send_load(key, $urandom_range(0, SEGMENTS - 1), pick_value(), pick_value());
        counted++;
      end else if (sel < 98) begin
        case ($urandom_range(0, 2))
          0: send_item(make_item(OP_UNUSED, 1'($urandom), SEGF_W'($urandom), BIN_W'($urandom),
                                 pick_value(), pick_value(), 1'($urandom)));
          1: send_item(make_item(OP_PUSH, 1'($urandom), SEGF_W'($urandom),
                                 BIN_W'($urandom_range(BINS, 511)), pick_value(), pick_value(),
                                 1'($urandom)));
          default: send_item(make_item(OP_LOAD, 1'($urandom), SEGF_W'($urandom),
                                       BIN_W'($urandom_range(BINS, 511)), pick_value(),
                                       pick_value(), 1'($urandom)));
        endcase
        counted++;
      end else begin
        wait_results_done();
      end
    end
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    int span;
    int cnt;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 400);
      cnt  = 0;
      repeat (span) begin
        @(negedge clk);
        cnt++;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ((cnt % 8) < 5);
          default: out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) pred.check_bin_result(out_ch.data);
  end

  initial begin
    int unsigned shift_plan [5] = '{0, 15, 0, 3, 12};
    int unsigned seg_plan [5]   = '{16, 1, 0, 31, 5};
    int          keys_pre [4];
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_SCALE_SHIFT;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    burst_left  = 0;
    clears_left = 3;
    build_key   = -1;
    pred = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full filters for the edge bins of both channels
    keys_pre = '{0, BINS - 1, BINS, 2 * BINS - 1};
    foreach (keys_pre[k]) begin
      for (int s = 0; s < SEGMENTS; s++) send_load(keys_pre[k], s, pick_value(), pick_value());
    end

    send_push(0, 0, VAL_MAX, VAL_MAX, 1'b0);
    send_push(0, 0, VAL_MIN, VAL_MIN, 1'b0);
    send_push(1, BINS - 1, VAL_MIN, VAL_MAX, 1'b1);
    send_push(1, BINS - 1, VAL_MAX, VAL_MIN, 1'b0);
    send_push(0, BINS - 1, '0, '0, 1'b1);
    send_load(0, SEGMENTS - 1, VAL_MIN, VAL_MIN);
    send_load(2 * BINS - 1, 0, VAL_MAX, VAL_MIN);
    send_push(0, 0, VAL_MIN, VAL_MIN, 1'b1);
    send_push(1, BINS - 1, VAL_MAX, VAL_MAX, 1'b1);
    // out-of-range bins and the unused opcode are dropped
    send_item(make_item(OP_PUSH, 1'b0, '0, BIN_W'(BINS), pick_value(), pick_value(), 1'b1));
    send_item(make_item(OP_PUSH, 1'b1, '1, '1, pick_value(), pick_value(), 1'b1));
    send_item(make_item(OP_LOAD, 1'b0, 4'd7, 9'd300, pick_value(), pick_value(), 1'b0));
    send_item(make_item(OP_UNUSED, 1'b1, '1, 9'd5, pick_value(), pick_value(), 1'b1));
    send_push(1, 0, pick_value(), pick_value(), 1'b0);
    // clear ignores its other fields
    send_item(make_item(OP_CLEAR, 1'b1, '1, '1, VAL_MIN, VAL_MAX, 1'b1));
    send_push(0, 0, VAL_MAX, VAL_MIN, 1'b0);
    send_push(1, BINS - 1, VAL_MIN, VAL_MIN, 1'b1);

    for (int p = 0; p < 9; p++) begin
      wait_results_done();
      if (p < 5) begin
        set_reg(CFG_SCALE_SHIFT, shift_plan[p]);
        set_reg(CFG_ACTIVE_SEGS, seg_plan[p]);
      end else begin
        set_reg(CFG_SCALE_SHIFT, $urandom_range(0, 15));
        set_reg(CFG_ACTIVE_SEGS, $urandom_range(0, 31));
      end
      run_random_phase(170);
    end

    in_ch.valid <= 1'b0;
    while (pred.expected_bins.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (pred.errors == 0 && pred.expected_bins.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
